// ===== sv/brf_pkg.sv =====
// types and constants shared by the byte ring fifo
`default_nettype none

package brf_pkg;

  localparam int KIND_W = 3;
  localparam int BYTE_W = 8;
  localparam int RLEN_W = 7;
  localparam int SLEN_W = 10;
  localparam int CNT_W  = 10;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 3'd0,
    KIND_READ  = 3'd1,
    KIND_PEEK  = 3'd2,
    KIND_SKIP  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] used_bytes;
    logic [CNT_W-1:0] free_bytes;
    logic [CNT_W-1:0] contiguous_readable;
    logic [CNT_W-1:0] contiguous_writable;
  } stat_t;

  typedef struct packed {
    logic byte_valid;
    logic last;
    logic accepted;
  } meta_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    meta_t             meta;
    stat_t             stat;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/brf_if.sv =====
// input and result channel interfaces of the byte ring fifo
`default_nettype none

interface brf_in_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::KIND_W-1:0]  kind;
  logic [brf_pkg::BYTE_W-1:0]  push_byte;
  logic [brf_pkg::RLEN_W-1:0]  read_length;
  logic [brf_pkg::SLEN_W-1:0]  skip_length;

  modport source(output valid, kind, push_byte, read_length, skip_length, input ready);
  modport sink(input valid, kind, push_byte, read_length, skip_length, output ready);
endinterface

interface brf_out_if;
  logic                       valid;
  logic                       ready;
  logic [brf_pkg::BYTE_W-1:0] out_byte;
  logic                       byte_valid;
  logic                       last;
  logic                       accepted;
  logic [brf_pkg::CNT_W-1:0]  used_bytes;
  logic [brf_pkg::CNT_W-1:0]  free_bytes;
  logic [brf_pkg::CNT_W-1:0]  contiguous_readable;
  logic [brf_pkg::CNT_W-1:0]  contiguous_writable;

  modport source(output valid, out_byte, byte_valid, last, accepted, used_bytes, free_bytes,
                 contiguous_readable, contiguous_writable, input ready);
  modport sink(input valid, out_byte, byte_valid, last, accepted, used_bytes, free_bytes,
               contiguous_readable, contiguous_writable, output ready);
endinterface

`default_nettype wire

// ===== sv/brf_mem.sv =====
// byte storage: one write port, one read port, registered read data
`default_nettype none

module brf_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [brf_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [brf_pkg::BYTE_W-1:0] rd_data
);

  logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/brf_status.sv =====
// occupancy and contiguous span counts from the head and tail indices
`default_nettype none

module brf_status #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic [AW-1:0] head,
  input  wire logic [AW-1:0] tail,
  output logic      [AW-1:0] used,
  output brf_pkg::stat_t     stat
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = CW + brf_pkg::CNT_W;
  localparam logic [CW-1:0] DEP  = CW'(DEPTH);
  localparam logic [CW-1:0] DEP1 = CW'(DEPTH - 1);
  localparam logic [CW-1:0] ONE  = CW'(1);

  logic [CW-1:0] h;
  logic [CW-1:0] t;
  logic          t_ge_h;
  logic [CW-1:0] used_w;
  logic [CW-1:0] free_w;
  logic [CW-1:0] crd_w;
  logic [CW-1:0] cwr_w;
  logic [EW-1:0] used_e;
  logic [EW-1:0] free_e;
  logic [EW-1:0] crd_e;
  logic [EW-1:0] cwr_e;

  always_comb begin
    h      = CW'(head);
    t      = CW'(tail);
    t_ge_h = (tail >= head);
    used_w = t_ge_h ? (t - h) : (t + DEP - h);
    free_w = t_ge_h ? (DEP1 - t + h) : (h - t - ONE);
    if (tail == head) begin
      crd_w = '0;
    end else if (head < tail) begin
      crd_w = t - h;
    end else begin
      crd_w = DEP - h;
    end
    if (t_ge_h) begin
      cwr_w = DEP - t - ((head == '0) ? ONE : '0);
    end else begin
      cwr_w = h - t - ONE;
    end
  end

  assign used_e = {{brf_pkg::CNT_W{1'b0}}, used_w};
  assign free_e = {{brf_pkg::CNT_W{1'b0}}, free_w};
  assign crd_e  = {{brf_pkg::CNT_W{1'b0}}, crd_w};
  assign cwr_e  = {{brf_pkg::CNT_W{1'b0}}, cwr_w};

  assign used                     = used_w[AW-1:0];
  assign stat.used_bytes          = used_e[brf_pkg::CNT_W-1:0];
  assign stat.free_bytes          = free_e[brf_pkg::CNT_W-1:0];
  assign stat.contiguous_readable = crd_e[brf_pkg::CNT_W-1:0];
  assign stat.contiguous_writable = cwr_e[brf_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/brf_outq.sv =====
// two-entry result queue driving the result channel
`default_nettype none

module brf_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire brf_pkg::res_t push_data,
  output logic [1:0]         cnt,
  output logic               pop,
  brf_out_if.source          out_ch
);

  brf_pkg::res_t q_r [2];
  logic          wr_ptr_r;
  logic          wr_ptr_nxt;
  logic          rd_ptr_r;
  logic          rd_ptr_nxt;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  brf_pkg::res_t head;

  assign head  = q_r[rd_ptr_r];
  assign pop   = out_ch.valid && out_ch.ready;
  assign cnt   = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_ch.valid               = (cnt_r != 2'd0);
  assign out_ch.out_byte            = head.out_byte;
  assign out_ch.byte_valid          = head.meta.byte_valid;
  assign out_ch.last                = head.meta.last;
  assign out_ch.accepted            = head.meta.accepted;
  assign out_ch.used_bytes          = head.stat.used_bytes;
  assign out_ch.free_bytes          = head.stat.free_bytes;
  assign out_ch.contiguous_readable = head.stat.contiguous_readable;
  assign out_ch.contiguous_writable = head.stat.contiguous_writable;

endmodule

`default_nettype wire

// ===== sv/byte_ring_fifo.sv =====
// byte ring fifo top level: control, index registers, storage and result queue
//
// in_ch carries one command per transfer: push, read, peek, skip or clear.
// out_ch returns the results; every result carries the occupancy counts
// (used, free, contiguous readable, contiguous writable) after the command.
// The ring has DEPTH slots and holds at most DEPTH-1 bytes.
// Push, skip, clear and read/peek that deliver nothing give one result each,
// so they can be accepted every cycle while the result queue has room.
// A read or peek of n bytes (n capped at MAX_BURST and at the bytes held) gives
// n results and holds the input until its last byte is fetched: one byte is
// fetched per cycle, while the result queue has room, through the single read
// port of the byte memory. A result passes through the memory read stage and
// then the result queue register before it is presented.
// Reset empties the ring (head and tail to zero) and the result queue; the
// byte memory itself is not cleared and needs no clearing pass.
// When the receiver stalls, the two-entry result queue fills and the block
// stops issuing: in_ch.ready drops and bursts pause, nothing is dropped.
`default_nettype none

module byte_ring_fifo #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  brf_in_if.sink     in_ch,
  brf_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int WW = AW + brf_pkg::SLEN_W + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [WW-1:0] DEP_W    = WW'(DEPTH);
  localparam logic [brf_pkg::RLEN_W-1:0] MB   = brf_pkg::RLEN_W'(MAX_BURST);
  localparam logic [brf_pkg::RLEN_W-1:0] ONE7 = brf_pkg::RLEN_W'(1);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : (p + 1'b1);
  endfunction

  brf_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [brf_pkg::RLEN_W-1:0] rem_r, rem_nxt;
  logic            fl_valid_r;
  brf_pkg::meta_t  fl_meta_r, fl_meta_nxt;
  logic            fl_issue;

  logic [AW-1:0]   used;
  brf_pkg::stat_t  stat;
  logic [1:0]      q_cnt;
  logic            q_pop;
  logic            issue_ok;
  logic            accept;

  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [brf_pkg::BYTE_W-1:0] mem_rdata;

  logic [brf_pkg::RLEN_W-1:0] rlen_c;
  logic [brf_pkg::RLEN_W-1:0] n_rd;
  logic [WW-1:0]   used_x;
  logic [WW-1:0]   adv;
  logic [WW-1:0]   sum;
  logic [WW-1:0]   sum_w;
  logic            full;
  brf_pkg::res_t   q_data;

  brf_status #(.DEPTH(DEPTH), .AW(AW)) u_status (
    .head (head_r),
    .tail (tail_r),
    .used (used),
    .stat (stat)
  );

  brf_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (tail_r),
    .wr_data (in_ch.push_byte),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    q_data.out_byte = fl_meta_r.byte_valid ? mem_rdata : '0;
    q_data.meta     = fl_meta_r;
    q_data.stat     = stat;
  end

  brf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fl_valid_r),
    .push_data (q_data),
    .cnt       (q_cnt),
    .pop       (q_pop),
    .out_ch    (out_ch)
  );

  // issue only if the fetched result is sure to find a queue slot
  assign issue_ok = ({1'b0, q_cnt} + {2'b00, fl_valid_r}) <= (3'd1 + {2'b00, q_pop});
  assign in_ch.ready = (state_r == brf_pkg::ST_IDLE) && issue_ok;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    full   = (used == LAST_IDX);
    used_x = WW'(used);
    rlen_c = (in_ch.read_length > MB) ? MB : in_ch.read_length;
    n_rd   = (used_x < WW'(rlen_c)) ? used_x[brf_pkg::RLEN_W-1:0] : rlen_c;
    adv    = (in_ch.kind == brf_pkg::KIND_SKIP) ? WW'(in_ch.skip_length) : WW'(n_rd);
    sum    = WW'(head_r) + adv;
    sum_w  = (sum >= DEP_W) ? (sum - DEP_W) : sum;
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    rd_ptr_nxt  = rd_ptr_r;
    rem_nxt     = rem_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr_r;
    fl_issue    = 1'b0;
    fl_meta_nxt = '{byte_valid: 1'b0, last: 1'b1, accepted: 1'b0};
    case (state_r)
      brf_pkg::ST_IDLE: begin
        if (accept) begin
          fl_issue = 1'b1;
          case (in_ch.kind)
            brf_pkg::KIND_PUSH: begin
              if (!full) begin
                mem_we               = 1'b1;
                tail_nxt             = idx_inc(tail_r);
                fl_meta_nxt.accepted = 1'b1;
              end
            end
            brf_pkg::KIND_READ, brf_pkg::KIND_PEEK: begin
              if (n_rd != '0) begin
                mem_re                 = 1'b1;
                mem_raddr              = head_r;
                rd_ptr_nxt             = idx_inc(head_r);
                rem_nxt                = n_rd - ONE7;
                fl_meta_nxt.byte_valid = 1'b1;
                fl_meta_nxt.last       = (n_rd == ONE7);
                if (n_rd != ONE7) begin
                  state_nxt = brf_pkg::ST_BURST;
                end
                if (in_ch.kind == brf_pkg::KIND_READ) begin
                  head_nxt = sum_w[AW-1:0];
                end
              end
            end
            brf_pkg::KIND_SKIP: begin
              if (WW'(in_ch.skip_length) <= used_x) begin
                head_nxt             = sum_w[AW-1:0];
                fl_meta_nxt.accepted = 1'b1;
              end
            end
            brf_pkg::KIND_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      brf_pkg::ST_BURST: begin
        if (issue_ok) begin
          fl_issue               = 1'b1;
          mem_re                 = 1'b1;
          rd_ptr_nxt             = idx_inc(rd_ptr_r);
          rem_nxt                = rem_r - ONE7;
          fl_meta_nxt.byte_valid = 1'b1;
          fl_meta_nxt.last       = (rem_r == ONE7);
          if (rem_r == ONE7) begin
            state_nxt = brf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = brf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= brf_pkg::ST_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      rd_ptr_r   <= '0;
      rem_r      <= '0;
      fl_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      rem_r      <= rem_nxt;
      fl_valid_r <= fl_issue;
    end
  end

  always_ff @(posedge clk) begin
    fl_meta_r <= fl_meta_nxt;
  end

  // fetch stage and result queue never hold more than the queue depth
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, q_cnt} + {2'b00, fl_valid_r}) <= 3'd2)
    else $error("result queue overflow");

  // burst state and remaining count agree
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brf_pkg::ST_BURST) == (rem_r != '0))
    else $error("burst count out of step with state");

  // a clear transfer empties the ring
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.kind == brf_pkg::KIND_CLEAR) |=> (head_r == '0 && tail_r == '0))
    else $error("clear did not reset indices");

  // only the final result of a command goes without a data byte
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    fl_valid_r |-> (fl_meta_r.byte_valid || fl_meta_r.last))
    else $error("status result not marked last");

endmodule

`default_nettype wire
